@@ src/gpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// gpfa_pkg: shared types and constants of the group pair flux accumulator
// Sizes, op codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package gpfa_pkg;

    // sizes
    localparam int MAX_ATOMS  = 1024;
    localparam int MAX_GROUPS = 64;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W     = 11;
    localparam int GID_W     = 7;
    localparam int OGRP_W    = 7;
    localparam int FIX_W     = 32;
    localparam int FLUX_W    = 64;
    localparam int ATOM_AW   = $clog2(MAX_ATOMS);
    localparam int ACC_DEPTH = MAX_GROUPS * MAX_GROUPS;
    localparam int ACC_AW    = $clog2(ACC_DEPTH);
    localparam int MUL_W     = FIX_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = PROD_W + FIX_W;
    localparam int IN_DW     = 224;
    localparam int OUT_DW    = 208;

    // op codes
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_ATOM  = 3'd2;
    localparam logic [2:0] OP_CELL  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef enum logic [1:0] {MUL_DOT, MUL_LO, MUL_HI} t_mul_sel;
    typedef enum logic [1:0] {ADR_IJ, ADR_JI, ADR_RD, ADR_CLR} t_adr_sel;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_ATOM_RD, S_CHECK, S_MUL, S_ADD, S_DVAL,
        S_HMUL_LO, S_HADD_LO, S_HMUL_HI, S_HADD_HI, S_HVAL,
        S_RMW_RD, S_RMW_WR, S_READ_RD, S_READ_OUT
    } t_state;

    typedef struct packed {
        logic     cap_in;
        logic     atom_wr;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic [1:0] comp;
        logic     acc_clr;
        logic     acc_add;
        logic     acc_sh32;
        logic     d_ld;
        logic     h_ld;
        t_adr_sel adr_sel;
        logic     acc_wr;
        logic     acc_sub;
        logic     acc_half;
        logic     clr_run;
        logic     out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic pair_ok;
        logic grp_ok;
        logic same_grp;
        logic mode;
        logic clr_done;
        logic out_busy;
    } t_dp_sts;

    // saturate a wide signed value to 64 bits
    function automatic logic signed [FLUX_W-1:0] sat_wide(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-FLUX_W:0] top;
        top = x[SUM_W-1:FLUX_W-1];
        if ((&top) || !(|top)) return x[FLUX_W-1:0];
        return x[SUM_W-1] ? {1'b1, {(FLUX_W-1){1'b0}}} : {1'b0, {(FLUX_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

@@ src/gpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// gpfa_ctrl: controller of the flux accumulator
// Sequences loads, clears, pair updates and reads over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module gpfa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire gpfa_pkg::t_dp_sts i_sts,
    output gpfa_pkg::t_dp_cmd      o_cmd
);
    import gpfa_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_comp, n_comp;
    logic       r_second, n_second;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_comp   <= '0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_comp   <= n_comp;
            r_second <= n_second;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_comp     = r_comp;
        n_second   = r_second;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.comp = r_comp;
        o_cmd.mul_sel = MUL_DOT;
        o_cmd.adr_sel = r_second ? ADR_JI : ADR_IJ;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_run = 1'b1;
                o_cmd.adr_sel = ADR_CLR;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.cap_in = i_in_valid;
                if (i_in_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                // captured item decides where to go
                case (i_sts.op)
                    OP_LOAD: begin
                        o_cmd.atom_wr = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_CLEAR: n_state = S_CLEAR;
                    OP_ATOM, OP_CELL: n_state = S_ATOM_RD;
                    OP_READ: n_state = S_READ_RD;
                    default: n_state = S_IDLE;
                endcase
            end
            S_ATOM_RD: n_state = S_CHECK;
            S_CHECK: begin
                o_cmd.acc_clr = 1'b1;
                n_comp   = '0;
                n_second = 1'b0;
                n_state  = (i_sts.pair_ok && i_sts.grp_ok) ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.acc_add = 1'b1;
                if (r_comp == 2'd2) begin
                    n_comp  = '0;
                    n_state = S_DVAL;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_DVAL: begin
                o_cmd.d_ld    = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state = i_sts.mode ? S_RMW_RD : S_HMUL_LO;
            end
            S_HMUL_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO;
                n_state = S_HADD_LO;
            end
            S_HADD_LO: begin
                o_cmd.acc_add = 1'b1;
                n_state = S_HMUL_HI;
            end
            S_HMUL_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HI;
                n_state = S_HADD_HI;
            end
            S_HADD_HI: begin
                o_cmd.acc_add  = 1'b1;
                o_cmd.acc_sh32 = 1'b1;
                n_state = S_HVAL;
            end
            S_HVAL: begin
                o_cmd.h_ld    = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state = S_RMW_RD;
            end
            S_RMW_RD: n_state = S_RMW_WR;
            S_RMW_WR: begin
                o_cmd.acc_wr   = 1'b1;
                o_cmd.acc_sub  = i_sts.mode && r_second;
                o_cmd.acc_half = i_sts.same_grp;
                if (!r_second && !i_sts.same_grp) begin
                    n_second = 1'b1;
                    n_state  = S_RMW_RD;
                end else begin
                    n_second = 1'b0;
                    if (i_sts.mode || r_comp == 2'd2) begin
                        n_comp  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = S_HMUL_LO;
                    end
                end
            end
            S_READ_RD: begin
                o_cmd.adr_sel = ADR_RD;
                n_state = S_READ_OUT;
            end
            S_READ_OUT: begin
                o_cmd.adr_sel = ADR_RD;
                if (!i_sts.out_busy) begin
                    o_cmd.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ src/gpfa_dp.sv @@
// ----------------------------------------------------------------------------
// gpfa_dp: datapath of the flux accumulator
// Atom tables, shared multiplier and wide sum, accumulator memories, output.
// ----------------------------------------------------------------------------
`default_nettype none

module gpfa_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gpfa_pkg::t_dp_cmd            i_cmd,
    output gpfa_pkg::t_dp_sts                 o_sts,
    input  wire logic [2:0]                   i_op,
    input  wire logic [gpfa_pkg::IN_DW-1:0]   i_data,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_mode,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [gpfa_pkg::OUT_DW-1:0]       o_out_data
);
    import gpfa_pkg::*;

    // captured item
    logic [2:0]              r_op;
    logic [IDX_W-1:0]        r_ia, r_ib;
    logic [GID_W-1:0]        r_gid;
    logic signed [FIX_W-1:0] r_f [3];
    logic signed [FIX_W-1:0] r_r [3];
    logic                    r_mode;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op  <= i_op;
            r_ia  <= i_data[10:0];
            r_ib  <= i_data[21:11];
            r_gid <= i_data[28:22];
            for (int c = 0; c < 3; c++) begin
                r_f[c] <= i_data[29 + 32*c +: 32];
                r_r[c] <= i_data[125 + 32*c +: 32];
            end
        end
    end

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= 1'b0;
        else if (i_cfg_we) r_mode <= i_cfg_mode;
    end

    // atom tables, one write and two read ports
    logic signed [FIX_W-1:0] mem_vx [MAX_ATOMS];
    logic signed [FIX_W-1:0] mem_vy [MAX_ATOMS];
    logic signed [FIX_W-1:0] mem_vz [MAX_ATOMS];
    logic [GID_W-1:0]        mem_g  [MAX_ATOMS];
    logic signed [FIX_W-1:0] r_vi [3];
    logic signed [FIX_W-1:0] r_vj [3];
    logic [GID_W-1:0]        r_gi, r_gj;
    logic [IDX_W-1:0]        ia_m1, ib_m1;
    logic [ATOM_AW-1:0]      idx_a, idx_b;
    logic                    ia_ok, ib_ok;
    logic [GID_W-1:0]        gid_st;

    assign ia_m1  = r_ia - 1'b1;
    assign ib_m1  = r_ib - 1'b1;
    assign idx_a  = ia_m1[ATOM_AW-1:0];
    assign idx_b  = ib_m1[ATOM_AW-1:0];
    assign ia_ok  = (r_ia != '0) && (r_ia <= IDX_W'(MAX_ATOMS));
    assign ib_ok  = (r_ib != '0) && (r_ib <= IDX_W'(MAX_ATOMS));
    assign gid_st = (r_gid > GID_W'(MAX_GROUPS)) ? '0 : r_gid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.atom_wr && ia_ok) begin
            mem_vx[idx_a] <= r_f[0];
            mem_vy[idx_a] <= r_f[1];
            mem_vz[idx_a] <= r_f[2];
            mem_g[idx_a]  <= gid_st;
        end
        r_vi[0] <= mem_vx[idx_a];
        r_vi[1] <= mem_vy[idx_a];
        r_vi[2] <= mem_vz[idx_a];
        r_gi    <= mem_g[idx_a];
        r_vj[0] <= mem_vx[idx_b];
        r_vj[1] <= mem_vy[idx_b];
        r_vj[2] <= mem_vz[idx_b];
        r_gj    <= mem_g[idx_b];
    end

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b, vel_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [FLUX_W-1:0] r_d, r_val;

    assign vel_sum = {r_vi[i_cmd.comp][FIX_W-1], r_vi[i_cmd.comp]}
                   + ((r_op == OP_CELL) ? '0 : {r_vj[i_cmd.comp][FIX_W-1], r_vj[i_cmd.comp]});

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LO: begin
                mul_a = {r_r[i_cmd.comp][FIX_W-1], r_r[i_cmd.comp]};
                mul_b = {1'b0, r_d[FIX_W-1:0]};
            end
            MUL_HI: begin
                mul_a = {r_r[i_cmd.comp][FIX_W-1], r_r[i_cmd.comp]};
                mul_b = {r_d[FLUX_W-1], r_d[FLUX_W-1:FIX_W]};
            end
            default: begin
                mul_a = {r_f[i_cmd.comp][FIX_W-1], r_f[i_cmd.comp]};
                mul_b = vel_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= mul_a * mul_b;
    end

    // wide sum of partial products
    logic signed [SUM_W-1:0] r_acc, prod_ext, acc_sh;

    assign prod_ext = i_cmd.acc_sh32
                    ? {r_prod, {FIX_W{1'b0}}}
                    : {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign acc_sh   = i_cmd.h_ld ? (r_acc >>> (FRAC_BITS + 1)) : (r_acc >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) r_acc <= '0;
        else if (i_cmd.acc_add) r_acc <= r_acc + prod_ext;
        if (i_cmd.d_ld) begin
            r_d   <= sat_wide(acc_sh);
            r_val <= sat_wide(acc_sh);
        end else if (i_cmd.h_ld) begin
            r_val <= sat_wide(acc_sh);
        end
    end

    // accumulator memories
    logic signed [FLUX_W-1:0] mem_ax [ACC_DEPTH];
    logic signed [FLUX_W-1:0] mem_ay [ACC_DEPTH];
    logic signed [FLUX_W-1:0] mem_az [ACC_DEPTH];
    logic signed [FLUX_W-1:0] r_rd [3];
    logic [ACC_AW-1:0]        r_clr_cnt, acc_adr;
    logic                     rd_ok;
    logic signed [FLUX_W:0]   rmw_sum;
    logic signed [FLUX_W-1:0] rmw_val, rmw_old, wdata;
    logic [2:0]               we;

    assign rd_ok = (r_ia != '0) && (r_ia <= IDX_W'(MAX_GROUPS))
                && (r_ib != '0) && (r_ib <= IDX_W'(MAX_GROUPS));

    always_comb begin
        case (i_cmd.adr_sel)
            ADR_IJ:  acc_adr = ACC_AW'((int'(r_gi) - 1) * MAX_GROUPS + int'(r_gj) - 1);
            ADR_JI:  acc_adr = ACC_AW'((int'(r_gj) - 1) * MAX_GROUPS + int'(r_gi) - 1);
            ADR_RD:  acc_adr = ACC_AW'((int'(r_ia) - 1) * MAX_GROUPS + int'(r_ib) - 1);
            default: acc_adr = r_clr_cnt;
        endcase
    end

    // saturating read-modify-write value
    assign rmw_val = i_cmd.acc_half ? (r_val >>> 1) : r_val;
    assign rmw_old = r_rd[i_cmd.comp];
    assign rmw_sum = i_cmd.acc_sub ? ({rmw_old[FLUX_W-1], rmw_old} - {rmw_val[FLUX_W-1], rmw_val})
                                   : ({rmw_old[FLUX_W-1], rmw_old} + {rmw_val[FLUX_W-1], rmw_val});

    always_comb begin
        if (i_cmd.clr_run) wdata = '0;
        else if (rmw_sum[FLUX_W] != rmw_sum[FLUX_W-1])
            wdata = rmw_sum[FLUX_W] ? {1'b1, {(FLUX_W-1){1'b0}}} : {1'b0, {(FLUX_W-1){1'b1}}};
        else wdata = rmw_sum[FLUX_W-1:0];
        for (int c = 0; c < 3; c++)
            we[c] = i_cmd.clr_run || (i_cmd.acc_wr && (i_cmd.comp == 2'(c)));
    end

    always_ff @(posedge i_clk) begin
        if (we[0]) mem_ax[acc_adr] <= wdata;
        if (we[1]) mem_ay[acc_adr] <= wdata;
        if (we[2]) mem_az[acc_adr] <= wdata;
        r_rd[0] <= mem_ax[acc_adr];
        r_rd[1] <= mem_ay[acc_adr];
        r_rd[2] <= mem_az[acc_adr];
    end

    // clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || !i_cmd.clr_run || o_sts.clr_done) r_clr_cnt <= '0;
        else r_clr_cnt <= r_clr_cnt + 1'b1;
    end

    // output register
    logic                     r_out_valid;
    logic [OGRP_W-1:0]        r_row, r_col;
    logic signed [FLUX_W-1:0] r_fx, r_fy, r_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.out_ld) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_row <= r_ia[OGRP_W-1:0];
            r_col <= r_ib[OGRP_W-1:0];
            r_fx  <= rd_ok ? r_rd[0] : '0;
            r_fy  <= (rd_ok && !r_mode) ? r_rd[1] : '0;
            r_fz  <= (rd_ok && !r_mode) ? r_rd[2] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {2'b00, r_fz, r_fy, r_fx, r_col, r_row};

    // status
    assign o_sts.op       = r_op;
    assign o_sts.pair_ok  = ia_ok && ib_ok;
    assign o_sts.grp_ok   = (r_gi != '0) && (r_gj != '0);
    assign o_sts.same_grp = (r_gi == r_gj);
    assign o_sts.mode     = r_mode;
    assign o_sts.clr_done = (r_clr_cnt == ACC_AW'(ACC_DEPTH - 1));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

@@ src/group_pair_flux_accumulator.sv @@
// ----------------------------------------------------------------------------
// group_pair_flux_accumulator: group-by-group heat or energy flux accumulator
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// One item is handled at a time; a read waits while the output register is
// still full. For a pair, the shared 33x33 multiplier forms the three f.v
// products and then, in heat mode, two partial products per heat component,
// and every accumulator update is a read-modify-write on the single-port
// accumulator memories. A clear, and the sweep after reset, zero the
// 4096-entry matrix one entry per cycle, so the block takes no item while the
// sweep runs; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module group_pair_flux_accumulator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // index_a[10:0], index_b[21:11], group_id[28:22], a_x, a_y, a_z, b_x, b_y,
    // b_z (32 bits each from bit 29), zero pad
    input  wire logic [gpfa_pkg::IN_DW-1:0] s_axis_tdata,
    // op[2:0]
    input  wire logic [2:0]                 s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // row_group[6:0], col_group[13:7], flux_x[77:14], flux_y[141:78],
    // flux_z[205:142], zero pad
    output logic [gpfa_pkg::OUT_DW-1:0]     m_axis_tdata,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic                       i_cfg_data
);
    import gpfa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    gpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gpfa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_mode  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // no item taken during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_run |-> !s_axis_tready)
        else $error("item accepted during clearing sweep");

    // accumulator updates never overlap the sweep
    a_no_rmw_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.acc_wr |-> !cmd.clr_run)
        else $error("accumulator update during clearing sweep");

    // a read result never overwrites one still waiting
    a_no_out_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_ld |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("output register overrun");

endmodule

`default_nettype wire
